// ===== hw/rtl/sorted_double_ended_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted double ended priority queue
// Concurrent checks clocked on the rising edge and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_DOUBLE_ENDED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_DOUBLE_ENDED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define SDPQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SDPQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sdpq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdpq_pkg
// Operation and status codes and the control structs of the queue.
// ----------------------------------------------------------------------------
package sdpq_pkg;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 16;
    localparam int OCNT_W   = 5;

    localparam logic [FUNC_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [FUNC_W-1:0] OP_POP_MIN = 2'd1;
    localparam logic [FUNC_W-1:0] OP_POP_MAX = 2'd2;
    localparam logic [FUNC_W-1:0] OP_NOP     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // Gated command into the cell row; at most one bit is set.
    typedef struct packed {
        logic push;
        logic pop_min;
        logic pop_max;
    } sdpq_cmd_t;

    // Occupancy flags of the current contents.
    typedef struct packed {
        logic full;
        logic empty;
    } sdpq_stat_t;

endpackage

// ===== hw/rtl/sorted_double_ended_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_double_ended_priority_queue
// Double ended priority queue kept sorted in a row of shift cells.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH key/tag entries in ascending key order; a push
// lands ahead of any equal keys, pop_min takes the front and pop_max the back.
// Every input item yields exactly one result item with the smallest and
// largest entries after the operation (zero when empty), the count and a
// status code. One item is taken per clock cycle, sustained while m_tready is
// high: the insert slot is found by a compare in every cell at once and the
// row shifts in the same cycle. An item passes the input register, then the
// result register. s_tready follows m_tready combinationally through the
// single result register. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
`include "sorted_double_ended_priority_queue_defines.svh"

module sorted_double_ended_priority_queue
    import sdpq_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] key, [31:16] tag
    input  logic [7:0]  s_tuser,   // [1:0] func, [7:2] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [15:0] min_key, [31:16] min_tag,
                                   // [47:32] max_key, [63:48] max_tag,
                                   // [68:64] entry_count, [71:69] zero
    output logic [7:0]  m_tuser    // [1:0] status, [7:2] zero
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Input register.
    logic                in_vld_reg;
    logic [FUNC_W-1:0]   in_func_reg;
    logic [KEY_BITS-1:0] in_key_reg;
    logic [TAG_BITS-1:0] in_tag_reg;

    // Result register.
    logic                out_vld_reg;
    logic                out_vld_next;
    logic [KEY_BITS-1:0] res_min_key_reg;
    logic [TAG_BITS-1:0] res_min_tag_reg;
    logic [KEY_BITS-1:0] res_max_key_reg;
    logic [TAG_BITS-1:0] res_max_tag_reg;
    logic [CNT_W-1:0]    res_cnt_reg;
    logic [STATUS_W-1:0] res_status_reg;

    logic                s_fire;
    logic                exec_fire;
    sdpq_cmd_t           cmd;
    sdpq_stat_t          stat;
    logic [STATUS_W-1:0] status_next;
    logic [CNT_W-1:0]    cnt_next;
    logic [KEY_BITS-1:0] min_key_next;
    logic [TAG_BITS-1:0] min_tag_next;
    logic [KEY_BITS-1:0] max_key_next;
    logic [TAG_BITS-1:0] max_tag_next;

    // Execute when an input item is held and the result slot is free or being drained this cycle.
    assign exec_fire = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || exec_fire;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    // Hold the payload unless a new item arrives.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_func_reg <= s_tuser[FUNC_W-1:0];
            in_key_reg  <= KEY_BITS'(s_tdata[15:0]);
            in_tag_reg  <= TAG_BITS'(s_tdata[31:16]);
        end
    end

    // Decode the operation; drop a push when full, ignore a pop when empty.
    always_comb begin
        cmd         = '0;
        status_next = ST_OK;
        unique case (in_func_reg)
            OP_PUSH: begin
                if (stat.full) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    cmd.push = exec_fire;
                end
            end
            OP_POP_MIN: begin
                if (stat.empty) begin
                    status_next = ST_UNDERFLOW;
                end else begin
                    cmd.pop_min = exec_fire;
                end
            end
            OP_POP_MAX: begin
                if (stat.empty) begin
                    status_next = ST_UNDERFLOW;
                end else begin
                    cmd.pop_max = exec_fire;
                end
            end
            OP_NOP: begin
                status_next = ST_OK;
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    sdpq_cells #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS),
        .CNT_W    (CNT_W)
    ) u_cells (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .push_key     (in_key_reg),
        .push_tag     (in_tag_reg),
        .stat         (stat),
        .cnt_next     (cnt_next),
        .min_key_next (min_key_next),
        .min_tag_next (min_tag_next),
        .max_key_next (max_key_next),
        .max_tag_next (max_tag_next)
    );

    // Advance the result slot on execute, drop it once taken.
    always_comb begin
        out_vld_next = out_vld_reg;
        if (exec_fire) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            res_min_key_reg <= min_key_next;
            res_min_tag_reg <= min_tag_next;
            res_max_key_reg <= max_key_next;
            res_max_tag_reg <= max_tag_next;
            res_cnt_reg     <= cnt_next;
            res_status_reg  <= status_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000,
                       OCNT_W'(res_cnt_reg),
                       FIELD_W'(res_max_tag_reg),
                       FIELD_W'(res_max_key_reg),
                       FIELD_W'(res_min_tag_reg),
                       FIELD_W'(res_min_key_reg)};
    assign m_tuser  = {6'b000000, res_status_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `SDPQ_ASSERT_NOW(a_ovf_full, aclk, aresetn,
        out_vld_reg && (res_status_reg == ST_OVERFLOW),
        res_cnt_reg == CNT_W'(DEPTH), "overflow reported with queue not full")
    `SDPQ_ASSERT_NOW(a_udf_empty, aclk, aresetn,
        out_vld_reg && (res_status_reg == ST_UNDERFLOW),
        (res_cnt_reg == '0) && (res_min_key_reg == '0) && (res_max_tag_reg == '0),
        "underflow reported with entries present")
    `SDPQ_ASSERT_NEXT(a_push_grows, aclk, aresetn, cmd.push,
        res_cnt_reg == $past(cnt_next) && out_vld_reg && (res_status_reg == ST_OK),
        "accepted push did not post its count")
    `SDPQ_ASSERT_NOW(a_one_cmd, aclk, aresetn, exec_fire || (cmd == '0),
        $countones(cmd) <= 1, "more than one command issued to cell row")

endmodule

// ===== hw/rtl/sdpq_cells.sv =====
// ----------------------------------------------------------------------------
// sdpq_cells
// Row of sorted key/tag cells with parallel insert compare and shifts.
// ----------------------------------------------------------------------------
module sdpq_cells
    import sdpq_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 16,
    parameter int CNT_W    = $clog2(DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sdpq_cmd_t           cmd,
    input  logic [KEY_BITS-1:0] push_key,
    input  logic [TAG_BITS-1:0] push_tag,
    output sdpq_stat_t          stat,
    output logic [CNT_W-1:0]    cnt_next,
    output logic [KEY_BITS-1:0] min_key_next,
    output logic [TAG_BITS-1:0] min_tag_next,
    output logic [KEY_BITS-1:0] max_key_next,
    output logic [TAG_BITS-1:0] max_tag_next
);

    logic [KEY_BITS-1:0] key_reg  [DEPTH];
    logic [TAG_BITS-1:0] tag_reg  [DEPTH];
    logic [KEY_BITS-1:0] key_next [DEPTH];
    logic [TAG_BITS-1:0] tag_next [DEPTH];
    logic [DEPTH-1:0]    vld_reg;
    logic [DEPTH-1:0]    vld_next;
    logic [CNT_W-1:0]    cnt_reg;

    // Neighbor views, padded at the ends of the row.
    logic [KEY_BITS-1:0] prv_key [DEPTH];
    logic [TAG_BITS-1:0] prv_tag [DEPTH];
    logic [KEY_BITS-1:0] nxt_key [DEPTH];
    logic [TAG_BITS-1:0] nxt_tag [DEPTH];
    logic [DEPTH-1:0]    prv_vld;
    logic [DEPTH-1:0]    nxt_vld;
    logic [DEPTH-1:0]    lt;
    logic [DEPTH-1:0]    prv_lt;
    logic [DEPTH-1:0]    last_next;

    for (genvar i = 0; i < DEPTH; i++) begin : g_nbr
        if (i == 0) begin : g_first
            assign prv_key[i] = '0;
            assign prv_tag[i] = '0;
            assign prv_vld[i] = 1'b1;
            assign prv_lt[i]  = 1'b0;
        end else begin : g_mid
            assign prv_key[i] = key_reg[i-1];
            assign prv_tag[i] = tag_reg[i-1];
            assign prv_vld[i] = vld_reg[i-1];
            assign prv_lt[i]  = lt[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign nxt_key[i] = '0;
            assign nxt_tag[i] = '0;
            assign nxt_vld[i] = 1'b0;
        end else begin : g_inner
            assign nxt_key[i] = key_reg[i+1];
            assign nxt_tag[i] = tag_reg[i+1];
            assign nxt_vld[i] = vld_reg[i+1];
        end
        // Entries are sorted, so lt is a run of ones from cell 0.
        assign lt[i] = vld_reg[i] && (key_reg[i] < push_key);
    end

    assign stat.full  = vld_reg[DEPTH-1];
    assign stat.empty = !vld_reg[0];

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            key_next[i] = key_reg[i];
            tag_next[i] = tag_reg[i];
            vld_next[i] = vld_reg[i];
            if (cmd.push) begin
                vld_next[i] = vld_reg[i] || prv_vld[i];
                if (!lt[i]) begin
                    if (i == 0 || prv_lt[i]) begin
                        key_next[i] = push_key;
                        tag_next[i] = push_tag;
                    end else begin
                        key_next[i] = prv_key[i];
                        tag_next[i] = prv_tag[i];
                    end
                end
            end else if (cmd.pop_min) begin
                key_next[i] = nxt_key[i];
                tag_next[i] = nxt_tag[i];
                vld_next[i] = nxt_vld[i];
            end else if (cmd.pop_max) begin
                vld_next[i] = vld_reg[i] && nxt_vld[i];
            end
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.push) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (cmd.pop_min || cmd.pop_max) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Select the back entry by its one-hot last flag.
    always_comb begin
        max_key_next = '0;
        max_tag_next = '0;
        for (int i = 0; i < DEPTH; i++) begin
            last_next[i] = vld_next[i] && ((i == DEPTH - 1) || !vld_next[(i + 1) % DEPTH]);
            max_key_next = max_key_next | (last_next[i] ? key_next[i] : '0);
            max_tag_next = max_tag_next | (last_next[i] ? tag_next[i] : '0);
        end
    end

    assign min_key_next = vld_next[0] ? key_next[0] : '0;
    assign min_tag_next = vld_next[0] ? tag_next[0] : '0;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            key_reg[i] <= key_next[i];
            tag_reg[i] <= tag_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            cnt_reg <= '0;
        end else begin
            vld_reg <= vld_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
